### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority request queue
// Entry layout kept in the slot memory, result layout, status codes and
// controller states.
// ----------------------------------------------------------------------------
package spq_pkg;

  // request operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // highest priority value; larger requests saturate to it
  localparam logic [6:0] TOP_PRIORITY = 7'd100;

  // result status codes
  typedef enum logic [1:0] {
    STS_INSERTED = 2'd0,
    STS_FULL     = 2'd1,
    STS_REMOVED  = 2'd2,
    STS_EMPTY    = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } state_t;

  // one stored request
  typedef struct packed {
    logic [6:0]  pri;
    logic [29:0] enr;
    logic [15:0] id;
  } entry_t;

  // one result beat
  typedef struct packed {
    status_t     status;
    logic [15:0] id;
    logic [29:0] enr;
    logic [4:0]  occ;
  } result_t;

endpackage

### hdl/spq_mem.sv
// ----------------------------------------------------------------------------
// spq_mem: slot memory of the request queue
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  spq_pkg::entry_t     wdata,
  input  logic [AW-1:0]       raddr,
  output spq_pkg::entry_t     rdata
);

  spq_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: queue controller
// Keeps the slot memory as a circular buffer sorted by priority. An insert
// walks back from the tail, moving larger-priority entries up one slot, and
// drops the new entry into the gap. A remove reads the head slot.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                clk,
  input  logic                rst,
  // request side
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [15:0]         request_id,
  input  logic [29:0]         enrollment,
  input  logic [6:0]          priority_req,
  // result side
  output logic                res_valid,
  input  logic                res_ready,
  output spq_pkg::result_t    res,
  // slot memory
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output spq_pkg::entry_t     mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  spq_pkg::entry_t     mem_rdata
);

  spq_pkg::state_t state, state_next;
  logic [AW-1:0]   head, tail, cur;
  logic [CW-1:0]   count, rem;
  spq_pkg::entry_t new_entry;
  logic            accept, is_full, is_empty, shift;
  logic [CW-1:0]   count_inc, count_dec;
  logic [6:0]      pri_sat;

  function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
    return (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
  endfunction

  assign accept    = in_valid && in_ready;
  assign is_full   = (count == CW'(CAPACITY));
  assign is_empty  = (count == '0);
  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);
  assign pri_sat   = (priority_req > spq_pkg::TOP_PRIORITY) ? spq_pkg::TOP_PRIORITY
                                                            : priority_req;

  // entry just read still sorts after the new one: move it up
  assign shift = (state == spq_pkg::ST_SCAN) && (rem != '0) &&
                 (mem_rdata.pri > new_entry.pri);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode == spq_pkg::MODE_REMOVE) begin
            state_next = is_empty ? spq_pkg::ST_DONE : spq_pkg::ST_POP;
          end else begin
            state_next = is_full ? spq_pkg::ST_DONE : spq_pkg::ST_SCAN;
          end
        end
      end
      spq_pkg::ST_SCAN: begin
        if (!shift) state_next = spq_pkg::ST_DONE;
      end
      spq_pkg::ST_POP:  state_next = spq_pkg::ST_DONE;
      spq_pkg::ST_DONE: begin
        if (res_ready) state_next = spq_pkg::ST_IDLE;
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = shift ? mem_rdata : new_entry;
    mem_raddr = head;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = (mode == spq_pkg::MODE_REMOVE) ? head : ptr_prev(tail);
      end
      spq_pkg::ST_SCAN: begin
        mem_we    = 1'b1;
        mem_raddr = ptr_prev(ptr_prev(cur));
      end
      spq_pkg::ST_POP:  mem_raddr = head;
      spq_pkg::ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == spq_pkg::ST_SCAN && !shift) begin
        tail  <= ptr_next(tail);
        count <= count_inc;
      end
      if (state == spq_pkg::ST_POP) begin
        head  <= ptr_next(head);
        count <= count_dec;
      end
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          new_entry.pri <= pri_sat;
          new_entry.enr <= enrollment;
          new_entry.id  <= request_id;
          cur           <= tail;
          rem           <= count;
          res.id        <= '0;
          res.enr       <= '0;
          res.occ       <= 5'(count);
          res.status    <= (mode == spq_pkg::MODE_REMOVE) ? spq_pkg::STS_EMPTY
                                                          : spq_pkg::STS_FULL;
        end
      end
      spq_pkg::ST_SCAN: begin
        if (shift) begin
          cur <= ptr_prev(cur);
          rem <= rem - CW'(1);
        end else begin
          res.status <= spq_pkg::STS_INSERTED;
          res.occ    <= 5'(count_inc);
        end
      end
      spq_pkg::ST_POP: begin
        res.status <= spq_pkg::STS_REMOVED;
        res.id     <= mem_rdata.id;
        res.enr    <= mem_rdata.enr;
        res.occ    <= 5'(count_dec);
      end
      spq_pkg::ST_DONE: ;
      default: ;
    endcase
  end

endmodule

### hdl/sorted_priority_request_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_request_queue: bounded priority queue of requests
// Requests leave in ascending priority, first in first out among equals.
// ----------------------------------------------------------------------------
// Entries live in one simple dual-port RAM used as a circular buffer kept in
// sorted order. A remove issues the head read, waits for the registered RAM
// read and hands the beat to the output register. A rejected beat (full
// insert, empty remove) goes straight to the output handoff. An insert moves
// each stored entry whose priority is greater than the new one up one slot:
// the controller walks back from the tail through the single RAM read port,
// moving one entry per cycle. The output register lets a finished beat wait
// while the next request is taken. Priorities above 100 are stored as 100.
// ----------------------------------------------------------------------------
module sorted_priority_request_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] request_id,
  input  logic [29:0] enrollment,
  input  logic [6:0]  priority_req,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] out_id,
  output logic [29:0] out_enrollment,
  output logic [4:0]  occupancy
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic             res_valid, res_ready, mem_we;
  spq_pkg::result_t res, out_q;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  spq_pkg::entry_t  mem_wdata, mem_rdata;

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .request_id   (request_id),
    .enrollment   (enrollment),
    .priority_req (priority_req),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  spq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign status         = out_q.status;
  assign out_id         = out_q.id;
  assign out_enrollment = out_q.enr;
  assign occupancy      = out_q.occ;

`ifndef SYNTHESIS
  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a dropped insert reports a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == spq_pkg::STS_FULL) |-> (occupancy == 5'(CAPACITY)))
    else $error("full status with queue not full");

  // an empty remove reports zero occupancy
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == spq_pkg::STS_EMPTY) |-> (occupancy == 5'd0))
    else $error("empty status with entries stored");

  // only a remove carries request data
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != spq_pkg::STS_REMOVED) |->
      (out_id == '0 && out_enrollment == '0))
    else $error("request data on a non-remove beat");
`endif

endmodule
